### sv/nmea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA sentence framer package
// Shared constants, types and helpers for the sentence framer and checker.
// ----------------------------------------------------------------------------
package nmea_pkg;

    // Stored bytes at which an unterminated line is discarded.
    localparam int LINE_LIMIT = 82;
    localparam int LEN_W      = 7;
    localparam int TAG_LEN    = 6;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_STAR = 8'h2A;

    // "$GPRMC", first character at index 0.
    localparam logic [7:0] RMC_TAG [TAG_LEN] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

    typedef enum logic [1:0] {
        ST_RMC_OK    = 2'd0,
        ST_OTHER_OK  = 2'd1,
        ST_CSUM_FAIL = 2'd2,
        ST_OVERLONG  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_SCAN = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef struct packed {
        status_t            status;
        logic [LEN_W-1:0]   line_length;
        logic [7:0]         computed_sum;
    } result_t;

    // Uppercase ASCII hex digit for one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] base;
        base = (nib < 4'd10) ? 8'h30 : 8'h37;
        return base + {4'd0, nib};
    endfunction

endpackage
`default_nettype wire

### sv/nmea_sentence_framer_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA sentence framer and checksum checker
// Frames CR/LF terminated lines from a byte stream and reports their status.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one received byte per transfer. Each non-empty line
//   closed by CR or LF produces one transfer on the m_ channel carrying the
//   status (valid RMC, valid other sentence, checksum failure), the stored
//   length and the XOR computed over the text. A line that reaches 82 stored
//   bytes without a terminator is discarded and reported as overlong.
//   A closing byte passes the input register, then the result register, to
//   reach m_valid. Throughput is one byte per cycle while the receiver
//   keeps up: the byte sits in an input register, then the line state and
//   the result register are updated in one pass of compare and XOR logic.
//   When the receiver stalls, the held result blocks the pipeline only once
//   both the input register and the result register are full; s_ready then
//   drops until m_ready returns.
//   Synchronous reset clears the line state and the valid flags of both
//   registers; no result is pending after reset.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [7:0]                  s_rx_byte,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [1:0]                       m_status,
    output logic [nmea_pkg::LEN_W-1:0]       m_line_length,
    output logic [7:0]                       m_computed_sum
);
    import nmea_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       m_valid_reg, m_valid_next;
    result_t    m_res_reg;
    logic       advance;
    logic       core_valid;
    result_t    core_res;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    nmea_line_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (advance),
        .byte_in   (in_byte_reg),
        .res_valid (core_valid),
        .res       (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (advance && core_valid) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && core_valid) begin
            m_res_reg <= core_res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_res_reg.status;
    assign m_line_length  = m_res_reg.line_length;
    assign m_computed_sum = m_res_reg.computed_sum;

endmodule
`default_nettype wire

### sv/nmea_line_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA line state and checksum core
// Holds the per-line state and turns one byte into at most one line result.
// ----------------------------------------------------------------------------
module nmea_line_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             byte_en,
    input  wire logic [7:0]       byte_in,
    output logic                  res_valid,
    output nmea_pkg::result_t     res
);
    import nmea_pkg::*;

    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [7:0]       xor_reg, xor_next;
    phase_t           phase_reg, phase_next;
    logic             dmatch_reg, dmatch_next;
    logic             pmatch_reg, pmatch_next;
    logic             ended_reg, ended_next;

    logic             is_term;
    logic             blank;
    logic             in_tag;

    assign is_term = (byte_in == CHAR_CR) || (byte_in == CHAR_LF);
    assign in_tag  = (fill_reg < LEN_W'(TAG_LEN));
    // A NUL as the first byte leaves the line empty; it is marked by a
    // cleared digit match while still scanning.
    assign blank   = (fill_reg == '0) || ((phase_reg == PH_SCAN) && !dmatch_reg);

    always_comb begin
        fill_next   = fill_reg;
        xor_next    = xor_reg;
        phase_next  = phase_reg;
        dmatch_next = dmatch_reg;
        pmatch_next = pmatch_reg;
        ended_next  = ended_reg;
        res_valid   = 1'b0;
        res.status       = ST_CSUM_FAIL;
        res.line_length  = fill_reg;
        res.computed_sum = xor_reg;

        if (byte_en) begin
            if (is_term) begin
                res_valid = !blank;
                if ((phase_reg == PH_DONE) && dmatch_reg) begin
                    res.status = (pmatch_reg && !in_tag) ? ST_RMC_OK : ST_OTHER_OK;
                end
                fill_next   = '0;
                xor_next    = '0;
                phase_next  = PH_SCAN;
                dmatch_next = 1'b1;
                pmatch_next = 1'b1;
                ended_next  = 1'b0;
            end else begin
                if (!ended_reg) begin
                    if (byte_in == CHAR_NUL) begin
                        ended_next = 1'b1;
                        if (in_tag) begin
                            pmatch_next = 1'b0;
                        end
                        if (fill_reg == '0) begin
                            dmatch_next = 1'b0;
                        end
                    end else begin
                        if (in_tag && (byte_in != RMC_TAG[fill_reg[2:0]])) begin
                            pmatch_next = 1'b0;
                        end
                        // The first byte of the line stays outside the checksum.
                        if (fill_reg != '0) begin
                            unique case (phase_reg)
                                PH_SCAN: begin
                                    if (byte_in == CHAR_STAR) begin
                                        phase_next = PH_HIGH;
                                    end else begin
                                        xor_next = xor_reg ^ byte_in;
                                    end
                                end
                                PH_HIGH: begin
                                    if (byte_in != hex_digit(xor_reg[7:4])) begin
                                        dmatch_next = 1'b0;
                                    end
                                    phase_next = PH_LOW;
                                end
                                PH_LOW: begin
                                    if (byte_in != hex_digit(xor_reg[3:0])) begin
                                        dmatch_next = 1'b0;
                                    end
                                    phase_next = PH_DONE;
                                end
                                PH_DONE: begin
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end

                fill_next = fill_reg + LEN_W'(1);
                if (fill_next == LEN_W'(LINE_LIMIT)) begin
                    res_valid        = 1'b1;
                    res.status       = ST_OVERLONG;
                    res.line_length  = LEN_W'(LINE_LIMIT);
                    res.computed_sum = xor_next;
                    fill_next   = '0;
                    xor_next    = '0;
                    phase_next  = PH_SCAN;
                    dmatch_next = 1'b1;
                    pmatch_next = 1'b1;
                    ended_next  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            xor_reg    <= '0;
            phase_reg  <= PH_SCAN;
            dmatch_reg <= 1'b1;
            pmatch_reg <= 1'b1;
            ended_reg  <= 1'b0;
        end else begin
            fill_reg   <= fill_next;
            xor_reg    <= xor_next;
            phase_reg  <= phase_next;
            dmatch_reg <= dmatch_next;
            pmatch_reg <= pmatch_next;
            ended_reg  <= ended_next;
        end
    end

endmodule
`default_nettype wire

### sv/nmea_chk_sva.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA sentence framer port checks
// Concurrent checks on the ports of the framer, bound to the top level.
// ----------------------------------------------------------------------------
module nmea_chk_sva (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic [7:0]                  s_rx_byte,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [1:0]                  m_status,
    input wire logic [nmea_pkg::LEN_W-1:0]  m_line_length,
    input wire logic [7:0]                  m_computed_sum
);
    import nmea_pkg::*;

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_line_length) && $stable(m_computed_sum))
        else $error("stalled result changed");

    // Nothing is pending right after reset.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Discards always report the full limit; judged lines are shorter and non-empty.
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_status == ST_OVERLONG) ? (m_line_length == LEN_W'(LINE_LIMIT))
            : ((m_line_length != '0) && (m_line_length < LEN_W'(LINE_LIMIT)))))
        else $error("line length inconsistent with status");

    // A good RMC sentence holds at least the tag, the star and two digits.
    a_rmc_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_RMC_OK) |-> m_line_length >= LEN_W'(TAG_LEN + 3))
        else $error("RMC sentence too short");

    // A waiting input transfer keeps its byte.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_rx_byte))
        else $error("waiting input transfer changed");

endmodule

bind nmea_sentence_framer_checker nmea_chk_sva u_nmea_chk_sva (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_rx_byte      (s_rx_byte),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_line_length  (m_line_length),
    .m_computed_sum (m_computed_sum)
);
`default_nettype wire

### tb/nmea_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA line checker
// Watches both channels of the sentence framer, predicts the status of every
// line from the accepted bytes and compares each result transfer with it.
// ----------------------------------------------------------------------------
module nmea_line_checker
    import nmea_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic [7:0]        s_rx_byte,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic [1:0]        m_status,
    input  wire logic [LEN_W-1:0]  m_line_length,
    input  wire logic [7:0]        m_computed_sum,
    output int                     fail_count,
    output int                     pending_count
);

    localparam logic [7:0] UPPER_HEX [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // Shadow of the line state inside the block.
    logic [LEN_W-1:0] fill_count;
    logic [7:0]       xor_acc;
    phase_t           digit_phase;
    logic             digits_ok;
    logic             tag_ok;
    logic             text_done;

    result_t line_results [$];
    int      mismatches = 0;

    function automatic void restart_line();
        fill_count  = '0;
        xor_acc     = 8'h00;
        digit_phase = PH_SCAN;
        digits_ok   = 1'b1;
        tag_ok      = 1'b1;
        text_done   = 1'b0;
    endfunction

    function automatic void post_result(input status_t st, input logic [LEN_W-1:0] len);
        result_t r;
        r.status       = st;
        r.line_length  = len;
        r.computed_sum = xor_acc;
        line_results.push_back(r);
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        logic [LEN_W-1:0] pos;
        logic             blank;
        pos = fill_count;
        if (b == CHAR_CR || b == CHAR_LF) begin
            // A NUL as the first byte leaves the scan phase with a cleared
            // digit flag, which marks the line as empty text.
            blank = (pos == 0) || (digit_phase == PH_SCAN && !digits_ok);
            if (!blank) begin
                if (digit_phase == PH_DONE && digits_ok) begin
                    post_result((tag_ok && pos >= TAG_LEN) ? ST_RMC_OK : ST_OTHER_OK, pos);
                end else begin
                    post_result(ST_CSUM_FAIL, pos);
                end
            end
            restart_line();
        end else begin
            if (!text_done) begin
                if (b == CHAR_NUL) begin
                    text_done = 1'b1;
                    if (pos < TAG_LEN) tag_ok = 1'b0;
                    if (pos == 0) digits_ok = 1'b0;
                end else begin
                    if (pos < TAG_LEN && b != RMC_TAG[pos]) tag_ok = 1'b0;
                    if (pos >= 1) begin
                        case (digit_phase)
                            PH_SCAN: begin
                                if (b == CHAR_STAR) digit_phase = PH_HIGH;
                                else xor_acc = xor_acc ^ b;
                            end
                            PH_HIGH: begin
                                if (b != UPPER_HEX[xor_acc[7:4]]) digits_ok = 1'b0;
                                digit_phase = PH_LOW;
                            end
                            PH_LOW: begin
                                if (b != UPPER_HEX[xor_acc[3:0]]) digits_ok = 1'b0;
                                digit_phase = PH_DONE;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            fill_count = pos + 1'b1;
            if (fill_count >= LINE_LIMIT) begin
                post_result(ST_OVERLONG, LEN_W'(LINE_LIMIT));
                restart_line();
            end
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            restart_line();
            line_results.delete();
        end else begin
            if (s_valid && s_ready) absorb_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                if (line_results.size() == 0) begin
                    $error("result with no line pending: status %0d length %0d sum %02h",
                           m_status, m_line_length, m_computed_sum);
                    mismatches++;
                end else begin
                    want = line_results.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        mismatches++;
                    end
                    if (m_line_length !== want.line_length) begin
                        $error("line_length: expected %0d, actual %0d",
                               want.line_length, m_line_length);
                        mismatches++;
                    end
                    if (m_computed_sum !== want.computed_sum) begin
                        $error("computed_sum: expected %02h, actual %02h",
                               want.computed_sum, m_computed_sum);
                        mismatches++;
                    end
                end
            end
        end
        pending_count <= line_results.size();
        fail_count    <= mismatches;
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence framer testbench
// Feeds directed and random NMEA lines with random gaps and receiver stalls;
// a separate checker predicts and compares every line status.
// ----------------------------------------------------------------------------
module tb_top;
    import nmea_pkg::*;

    localparam int BYTE_TARGET = 1450;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_ready   = 1'b0;

    wire logic             s_ready;
    wire logic             m_valid;
    wire logic [1:0]       m_status;
    wire logic [LEN_W-1:0] m_line_length;
    wire logic [7:0]       m_computed_sum;

    int fail_count;
    int pending_count;

    logic       hold_off_req = 1'b0;
    int         bytes_sent   = 0;
    int         burst_left   = 0;
    logic [7:0] line_q [$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    nmea_sentence_framer_checker dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_line_length  (m_line_length),
        .m_computed_sum (m_computed_sum)
    );

    nmea_line_checker line_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_line_length  (m_line_length),
        .m_computed_sum (m_computed_sum),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    // ---------------- line construction ----------------

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        c = 8'($urandom_range(32, 126));
        if (c == CHAR_STAR) c = 8'h2C;
        return c;
    endfunction

    function automatic logic [7:0] upper_letter();
        return 8'($urandom_range(65, 90));
    endfunction

    function automatic logic [7:0] non_terminator();
        logic [7:0] c;
        c = 8'($urandom);
        if (c == CHAR_CR || c == CHAR_LF) c = c ^ 8'h80;
        return c;
    endfunction

    function automatic void add_text(input string text);
        for (int i = 0; i < text.len(); i++) line_q.push_back(text[i]);
    endfunction

    function automatic void add_terminator();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            line_q.push_back(CHAR_CR);
        end else if (r < 90) begin
            line_q.push_back(CHAR_LF);
        end else begin
            line_q.push_back(CHAR_CR);
            line_q.push_back(CHAR_LF);
        end
    endfunction

    // Star and two digits over everything after the first byte, optionally
    // spoiled so the comparison fails in most cases.
    function automatic void append_checksum(input logic corrupt);
        logic [7:0] sum;
        logic [7:0] hi;
        logic [7:0] lo;
        sum = 8'h00;
        for (int i = 1; i < line_q.size(); i++) sum = sum ^ line_q[i];
        hi = hex_char(sum[7:4]);
        lo = hex_char(sum[3:0]);
        if (corrupt) begin
            case ($urandom_range(0, 2))
                0: hi = hi ^ 8'h20;
                1: lo = hex_char(sum[3:0] + 4'($urandom_range(1, 15)));
                default: hi = 8'($urandom);
            endcase
        end
        line_q.push_back(CHAR_STAR);
        line_q.push_back(hi);
        line_q.push_back(lo);
    endfunction

    function automatic void add_sentence_text();
        int head;
        int body_len;
        head = $urandom_range(0, 9);
        if (head < 5) begin
            add_text("$GPRMC");
        end else if (head < 7) begin
            add_text("$GPRMC");
            line_q[$urandom_range(0, 5)] = upper_letter();
        end else begin
            add_text("$");
            repeat (5) line_q.push_back(upper_letter());
        end
        body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 70) : $urandom_range(0, 20);
        repeat (body_len) line_q.push_back(text_byte());
    endfunction

    function automatic void build_random_line();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            add_sentence_text();
            append_checksum($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) line_q.push_back(text_byte());
        end else if (r < 68) begin
            // Star missing, or the digits cut short.
            add_sentence_text();
            n = $urandom_range(0, 2);
            if (n > 0) line_q.push_back(CHAR_STAR);
            if (n > 1) line_q.push_back(hex_char(4'($urandom)));
        end else if (r < 76) begin
            add_sentence_text();
            append_checksum($urandom_range(0, 3) == 0);
            line_q[$urandom_range(0, line_q.size() - 1)] = CHAR_NUL;
        end else if (r < 80) begin
            case ($urandom_range(0, 2))
                0: n = LINE_LIMIT - 1;
                1: n = LINE_LIMIT;
                default: n = LINE_LIMIT + $urandom_range(1, 20);
            endcase
            if ($urandom_range(0, 1)) add_text("$GPRMC");
            while (line_q.size() < n) line_q.push_back(non_terminator());
        end else if (r < 90) begin
            repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom));
        end else begin
            // Short sentence whose head is below the length of the RMC tag.
            if ($urandom_range(0, 3) == 0) begin
                line_q.push_back(CHAR_STAR);
            end else begin
                add_text("$");
                repeat ($urandom_range(0, 4)) line_q.push_back(upper_letter());
                append_checksum($urandom_range(0, 9) == 0);
            end
        end
        add_terminator();
    endfunction

    // ---------------- sender ----------------

    task automatic sender_gap();
        int r;
        int n;
        n = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) n = 0;
            else if (r < 85) n = $urandom_range(1, 3);
            else if (r < 93) n = $urandom_range(4, 12);
            else if (r < 97) n = $urandom_range(20, 60);
            else burst_left = $urandom_range(20, 100);
        end
        if (n > 0) begin
            s_valid   <= 1'b0;
            s_rx_byte <= 8'($urandom);
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        sender_gap();
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_byte(line_q[i]);
        line_q.delete();
    endtask

    task automatic wait_for_drain(input int max_cycles);
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0 && waited < max_cycles) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    // ---------------- receiver ----------------

    initial begin : receiver
        int   stall_left;
        int   calm_left;
        int   r;
        logic hold_off_done;
        stall_left    = 0;
        calm_left     = 0;
        hold_off_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (hold_off_req && !hold_off_done) begin
                // Long hold-off so the block fills up and stalls its input.
                hold_off_done = 1'b1;
                m_ready <= 1'b0;
                stall_left = 300;
            end else if (calm_left > 0) begin
                m_ready <= 1'b1;
                calm_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    m_ready <= 1'b1;
                end else if (r < 88) begin
                    m_ready <= 1'b0;
                    stall_left = $urandom_range(0, 3);
                end else if (r < 95) begin
                    m_ready <= 1'b0;
                    stall_left = $urandom_range(4, 15);
                end else if (r < 97) begin
                    m_ready <= 1'b0;
                    stall_left = $urandom_range(30, 80);
                end else begin
                    m_ready <= 1'b1;
                    calm_left = $urandom_range(30, 100);
                end
            end
        end
    end

    // ---------------- stimulus and verdict ----------------

    initial begin : stimulus
        logic hold_done;
        logic drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty lines on both terminators.
        line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_LF);
        send_line();
        // Good RMC sentence.
        add_text("$GPRMC");
        append_checksum(1'b0);
        line_q.push_back(CHAR_CR);
        // Star as the first byte, then no digits.
        line_q.push_back(CHAR_STAR);
        line_q.push_back(CHAR_LF);
        // NUL as the first byte gives empty text.
        line_q.push_back(CHAR_NUL);
        line_q.push_back(CHAR_CR);
        // NUL ends the text before any star.
        add_text("X");
        line_q.push_back(8'hFF);
        line_q.push_back(CHAR_NUL);
        line_q.push_back(CHAR_LF);
        send_line();
        // Short but well-formed other sentence.
        add_text("$A");
        append_checksum(1'b0);
        line_q.push_back(CHAR_LF);
        send_line();

        while (bytes_sent < BYTE_TARGET) begin
            if (!hold_done && bytes_sent >= 450) begin
                hold_done = 1'b1;
                hold_off_req <= 1'b1;
                repeat (16) begin
                    line_q.push_back(CHAR_STAR);
                    line_q.push_back(CHAR_CR);
                    send_line();
                end
            end
            if (!drain_done && bytes_sent >= 950) begin
                drain_done = 1'b1;
                wait_for_drain(100000);
            end
            build_random_line();
            send_line();
        end

        wait_for_drain(20000);
        repeat (20) @(posedge aclk);
        if (pending_count != 0) $error("%0d expected results never arrived", pending_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
sv/nmea_pkg.sv
sv/nmea_line_core.sv
sv/nmea_sentence_framer_checker.sv
sv/nmea_chk_sva.sv
tb/nmea_line_checker.sv
tb/tb_top.sv
